@@ rtl/core/bbi_pkg.sv @@
package bbi_pkg;

    localparam int RATIO_BITS = 16;
    localparam logic [RATIO_BITS-1:0] RATIO_MAX = {RATIO_BITS{1'b1}};

endpackage

@@ rtl/core/bbi_front.sv @@
module bbi_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [COORD_BITS-1:0]     first_left,
    input  logic [COORD_BITS-1:0]     first_top,
    input  logic [COORD_BITS-1:0]     first_width,
    input  logic [COORD_BITS-1:0]     first_height,
    input  logic [COORD_BITS-1:0]     second_left,
    input  logic [COORD_BITS-1:0]     second_top,
    input  logic [COORD_BITS-1:0]     second_width,
    input  logic [COORD_BITS-1:0]     second_height,
    output logic                      push_valid,
    input  logic                      push_ready,
    output logic [2*COORD_BITS-1:0]   push_inter,
    output logic [2*COORD_BITS:0]     push_union
);

    localparam int CW = COORD_BITS;
    localparam int AW = 2 * COORD_BITS;

    logic          adv;
    logic [CW:0]   far_x1;
    logic [CW:0]   far_x2;
    logic [CW:0]   far_y1;
    logic [CW:0]   far_y2;
    logic [CW:0]   hi_x;
    logic [CW:0]   hi_y;
    logic [CW-1:0] lo_x;
    logic [CW-1:0] lo_y;
    logic [CW-1:0] ext_x_next;
    logic [CW-1:0] ext_y_next;

    logic          a_valid_reg;
    logic [CW-1:0] ext_x_reg;
    logic [CW-1:0] ext_y_reg;
    logic [CW-1:0] w1_reg;
    logic [CW-1:0] h1_reg;
    logic [CW-1:0] w2_reg;
    logic [CW-1:0] h2_reg;

    logic          b_valid_reg;
    logic [AW-1:0] area1_reg;
    logic [AW-1:0] area2_reg;
    logic [AW-1:0] inter_reg;

    assign adv      = !b_valid_reg || push_ready;
    assign in_ready = adv;

    always_comb
    begin
        far_x1 = {1'b0, first_left}  + {1'b0, first_width};
        far_x2 = {1'b0, second_left} + {1'b0, second_width};
        far_y1 = {1'b0, first_top}   + {1'b0, first_height};
        far_y2 = {1'b0, second_top}  + {1'b0, second_height};
        hi_x   = (far_x1 < far_x2) ? far_x1 : far_x2;
        hi_y   = (far_y1 < far_y2) ? far_y1 : far_y2;
        lo_x   = (first_left > second_left) ? first_left : second_left;
        lo_y   = (first_top > second_top) ? first_top : second_top;
        ext_x_next = (hi_x > {1'b0, lo_x}) ? CW'(hi_x - {1'b0, lo_x}) : '0;
        ext_y_next = (hi_y > {1'b0, lo_y}) ? CW'(hi_y - {1'b0, lo_y}) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ext_x_reg <= ext_x_next;
            ext_y_reg <= ext_y_next;
            w1_reg    <= first_width;
            h1_reg    <= first_height;
            w2_reg    <= second_width;
            h2_reg    <= second_height;
            area1_reg <= w1_reg * h1_reg;
            area2_reg <= w2_reg * h2_reg;
            inter_reg <= ext_x_reg * ext_y_reg;
        end
    end

    assign push_valid = b_valid_reg;
    assign push_inter = inter_reg;
    assign push_union = {1'b0, area1_reg} + {1'b0, area2_reg} - {1'b0, inter_reg};

endmodule

@@ rtl/core/bbi_queue.sv @@
module bbi_queue #(
    parameter int DATA_BITS = 49,
    parameter int DEPTH     = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  logic [DATA_BITS-1:0] wr_data,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output logic [DATA_BITS-1:0] rd_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] store_reg [DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg;
    logic [PTR_BITS-1:0]  wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg;
    logic [PTR_BITS-1:0]  rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg;
    logic [CNT_BITS-1:0]  count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign wr_ready = (count_reg != CNT_BITS'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = store_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_BITS'(do_wr) - CNT_BITS'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/core/bbi_back.sv @@
module bbi_back #(
    parameter int COORD_BITS    = 12,
    parameter int FRACTION_BITS = 15
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pop_valid,
    output logic                       pop_ready,
    input  logic [2*COORD_BITS-1:0]    pop_inter,
    input  logic [2*COORD_BITS:0]      pop_union,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [bbi_pkg::RATIO_BITS-1:0] overlap_ratio,
    output logic                       union_empty
);

    import bbi_pkg::*;

    localparam int UW     = 2 * COORD_BITS + 1;
    localparam int RW     = UW + 1;
    localparam int QW     = FRACTION_BITS + 1;
    localparam int STAGES = FRACTION_BITS + 1;

    logic          adv;
    logic          valid_reg [STAGES];
    logic [RW-1:0] rem_reg   [STAGES];
    logic [QW-1:0] quot_reg  [STAGES];
    logic [UW-1:0] div_reg   [STAGES];
    logic          empty_reg [STAGES];

    logic                  out_valid_reg;
    logic [RATIO_BITS-1:0] ratio_reg;
    logic                  empty_out_reg;
    logic [RATIO_BITS-1:0] ratio_next;
    logic [QW+RATIO_BITS:0] quot_wide;

    assign adv       = !out_valid_reg || out_ready;
    assign pop_ready = adv;

    // One quotient bit per stage; the first stage gives the integer bit.
    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [RW-1:0] rem_in;
        logic [QW-1:0] quot_in;
        logic [UW-1:0] div_in;
        logic          empty_in;
        logic          valid_in;
        logic          ge;

        if (s == 0)
        begin : g_first
            assign rem_in   = RW'(pop_inter);
            assign quot_in  = '0;
            assign div_in   = pop_union;
            assign empty_in = (pop_union == '0);
            assign valid_in = pop_valid;
        end
        else
        begin : g_rest
            assign rem_in   = {rem_reg[s-1][RW-2:0], 1'b0};
            assign quot_in  = quot_reg[s-1];
            assign div_in   = div_reg[s-1];
            assign empty_in = empty_reg[s-1];
            assign valid_in = valid_reg[s-1];
        end

        assign ge = (rem_in >= {1'b0, div_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[s] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s]   <= ge ? (rem_in - {1'b0, div_in}) : rem_in;
                quot_reg[s]  <= {quot_in[QW-2:0], ge};
                div_reg[s]   <= div_in;
                empty_reg[s] <= empty_in;
            end
        end
    end

    always_comb
    begin
        quot_wide = (QW + RATIO_BITS + 1)'(quot_reg[STAGES-1]);
        if (empty_reg[STAGES-1])
        begin
            ratio_next = '0;
        end
        else if ((quot_wide >> RATIO_BITS) != '0)
        begin
            ratio_next = RATIO_MAX;
        end
        else
        begin
            ratio_next = quot_wide[RATIO_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= valid_reg[STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ratio_reg     <= ratio_next;
            empty_out_reg <= empty_reg[STAGES-1];
        end
    end

    assign out_valid     = out_valid_reg;
    assign overlap_ratio = ratio_reg;
    assign union_empty   = empty_out_reg;

endmodule

@@ rtl/core/bbox_iou.sv @@
// Intersection over union of two axis-aligned boxes, each given as left, top,
// width and height. The input channel (in_valid, in_ready) takes one box pair
// per beat; the output channel (out_valid, out_ready) returns one beat per
// pair carrying overlap_ratio, an unsigned fraction with FRACTION_BITS
// fraction bits, and union_empty, which is set when both boxes have no area.
// A pair is accepted every cycle while the receiver keeps up, so the block
// sustains one beat per cycle. From the input beat to the output beat, a pair
// passes through the registered edge and area arithmetic, the queue,
// FRACTION_BITS + 1 divider stages producing one quotient bit each, and the
// output register.
// The front end and the divider are separated by a two-entry queue. When the
// receiver stalls, the divider pipeline and output hold their contents; the
// front end keeps accepting until the queue is full, then drops in_ready.
// Reset clears every valid flag, so no beat is presented after reset until
// new pairs arrive. Results emerge in the order the pairs were accepted.
module bbox_iou #(
    parameter int COORD_BITS    = 12,
    parameter int FRACTION_BITS = 15
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [COORD_BITS-1:0]          first_left,
    input  logic [COORD_BITS-1:0]          first_top,
    input  logic [COORD_BITS-1:0]          first_width,
    input  logic [COORD_BITS-1:0]          first_height,
    input  logic [COORD_BITS-1:0]          second_left,
    input  logic [COORD_BITS-1:0]          second_top,
    input  logic [COORD_BITS-1:0]          second_width,
    input  logic [COORD_BITS-1:0]          second_height,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bbi_pkg::RATIO_BITS-1:0] overlap_ratio,
    output logic                           union_empty
);

    import bbi_pkg::*;

    localparam int AW = 2 * COORD_BITS;
    localparam int UW = AW + 1;
    localparam int DW = AW + UW;

    logic          push_valid;
    logic          push_ready;
    logic [AW-1:0] push_inter;
    logic [UW-1:0] push_union;
    logic          pop_valid;
    logic          pop_ready;
    logic [DW-1:0] pop_data;
    logic [RATIO_BITS-1:0] ratio;

    bbi_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .first_left    (first_left),
        .first_top     (first_top),
        .first_width   (first_width),
        .first_height  (first_height),
        .second_left   (second_left),
        .second_top    (second_top),
        .second_width  (second_width),
        .second_height (second_height),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_inter    (push_inter),
        .push_union    (push_union)
    );

    bbi_queue #(
        .DATA_BITS (DW),
        .DEPTH     (2)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  ({push_inter, push_union}),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data)
    );

    bbi_back #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_inter     (pop_data[DW-1:UW]),
        .pop_union     (pop_data[UW-1:0]),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .overlap_ratio (ratio),
        .union_empty   (union_empty)
    );

    assign overlap_ratio = ratio;

endmodule

@@ tb/sv/bbox_iou_test.sv @@
module bbox_iou_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS    = 12;
    localparam int FRACTION_BITS = 15;
    localparam int RANDOM_PAIRS  = 1630;
    localparam int TAIL_PAIRS    = 150;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 2 * FRACTION_BITS + 10;
    localparam int CYCLE_LIMIT   = 400000;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic   drain;
        coord_t first_left;
        coord_t first_top;
        coord_t first_width;
        coord_t first_height;
        coord_t second_left;
        coord_t second_top;
        coord_t second_width;
        coord_t second_height;
    } box_pair_t;

    typedef struct packed {
        logic [bbi_pkg::RATIO_BITS-1:0] ratio;
        logic                           empty;
    } score_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [bbi_pkg::RATIO_BITS-1:0] overlap_ratio;
    logic union_empty;
    box_pair_t offered = '0;

    box_pair_t pending_pairs[$];
    score_t    expected_scores[$];
    int idle_left = 0;
    int hold_left = 0;
    int results_seen = 0;
    bit long_hold_done = 1'b0;
    int error_count = 0;
    int cycle_count = 0;

    bbox_iou #(
        .COORD_BITS   (COORD_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .first_left   (offered.first_left),
        .first_top    (offered.first_top),
        .first_width  (offered.first_width),
        .first_height (offered.first_height),
        .second_left  (offered.second_left),
        .second_top   (offered.second_top),
        .second_width (offered.second_width),
        .second_height(offered.second_height),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .overlap_ratio(overlap_ratio),
        .union_empty  (union_empty)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < 40)
        begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
        error_count++;
    endtask

    function automatic logic [63:0] overlap_extent(input coord_t near_a, input coord_t size_a,
                                                   input coord_t near_b, input coord_t size_b);
        logic [63:0] far_a;
        logic [63:0] far_b;
        logic [63:0] hi;
        logic [63:0] lo;
        far_a = 64'(near_a) + 64'(size_a);
        far_b = 64'(near_b) + 64'(size_b);
        hi = (far_a < far_b) ? far_a : far_b;
        lo = (near_a > near_b) ? 64'(near_a) : 64'(near_b);
        return (hi > lo) ? hi - lo : 64'd0;
    endfunction

    function automatic score_t predict_score(input box_pair_t p);
        logic [63:0] ex;
        logic [63:0] ey;
        logic [63:0] inter;
        logic [63:0] uni;
        logic [63:0] quotient;
        score_t s;
        ex = overlap_extent(p.first_left, p.first_width, p.second_left, p.second_width);
        ey = overlap_extent(p.first_top, p.first_height, p.second_top, p.second_height);
        inter = ex * ey;
        uni = 64'(p.first_width) * 64'(p.first_height)
            + 64'(p.second_width) * 64'(p.second_height) - inter;
        s = '0;
        if (uni == 64'd0)
        begin
            s.empty = 1'b1;
        end
        else
        begin
            quotient = (inter << FRACTION_BITS) / uni;
            s.ratio = (quotient > 64'(bbi_pkg::RATIO_MAX)) ? bbi_pkg::RATIO_MAX
                                                           : quotient[bbi_pkg::RATIO_BITS-1:0];
        end
        return s;
    endfunction

    function automatic box_pair_t make_pair(input int l1, input int t1, input int w1, input int h1,
                                            input int l2, input int t2, input int w2, input int h2);
        box_pair_t p;
        p = '0;
        p.first_left    = coord_t'(l1);
        p.first_top     = coord_t'(t1);
        p.first_width   = coord_t'(w1);
        p.first_height  = coord_t'(h1);
        p.second_left   = coord_t'(l2);
        p.second_top    = coord_t'(t2);
        p.second_width  = coord_t'(w2);
        p.second_height = coord_t'(h2);
        return p;
    endfunction

    function automatic box_pair_t random_pair();
        box_pair_t p;
        int span;
        p = '0;
        p.first_left    = coord_t'($urandom);
        p.first_top     = coord_t'($urandom);
        p.first_width   = coord_t'($urandom);
        p.first_height  = coord_t'($urandom);
        p.second_left   = coord_t'($urandom);
        p.second_top    = coord_t'($urandom);
        p.second_width  = coord_t'($urandom);
        p.second_height = coord_t'($urandom);
        case ($urandom_range(0, 9))
            2, 3, 4:
            begin
                // Boxes of similar size placed close together, so most pairs overlap.
                span = 1 << $urandom_range(1, 11);
                p.first_width   = coord_t'($urandom_range(0, span));
                p.first_height  = coord_t'($urandom_range(0, span));
                p.second_width  = coord_t'($urandom_range(0, span));
                p.second_height = coord_t'($urandom_range(0, span));
                p.second_left = p.first_left + coord_t'($urandom_range(0, 2 * span))
                              - coord_t'(span);
                p.second_top  = p.first_top + coord_t'($urandom_range(0, 2 * span))
                              - coord_t'(span);
            end
            5:
            begin
                p.second_left   = p.first_left;
                p.second_top    = p.first_top;
                p.second_width  = p.first_width;
                p.second_height = p.first_height;
            end
            6:
            begin
                if ($urandom_range(0, 1) == 0)
                    p.first_width = '0;
                else
                    p.first_height = '0;
                if ($urandom_range(0, 2) == 0)
                    p.second_width = '0;
                else if ($urandom_range(0, 1) == 0)
                    p.second_height = '0;
            end
            7:
            begin
                // The second box lies inside the first.
                p.first_left   = coord_t'($urandom_range(0, 2047));
                p.first_top    = coord_t'($urandom_range(0, 2047));
                p.first_width  = coord_t'($urandom_range(0, 2047));
                p.first_height = coord_t'($urandom_range(0, 2047));
                p.second_left  = p.first_left + coord_t'($urandom_range(0, p.first_width));
                p.second_top   = p.first_top + coord_t'($urandom_range(0, p.first_height));
                p.second_width = coord_t'($urandom_range(0,
                                     p.first_left + p.first_width - p.second_left));
                p.second_height = coord_t'($urandom_range(0,
                                     p.first_top + p.first_height - p.second_top));
            end
            8:
            begin
                // Far edges run past the coordinate range.
                p.first_left    = coord_t'($urandom_range(3072, 4095));
                p.second_left   = coord_t'($urandom_range(3072, 4095));
                p.first_top     = coord_t'($urandom_range(3072, 4095));
                p.second_top    = coord_t'($urandom_range(3072, 4095));
                p.first_width   = coord_t'($urandom_range(2048, 4095));
                p.second_width  = coord_t'($urandom_range(2048, 4095));
                p.first_height  = coord_t'($urandom_range(2048, 4095));
                p.second_height = coord_t'($urandom_range(2048, 4095));
            end
            9:
            begin
                // Disjoint or just touching along one axis.
                if ($urandom_range(0, 1) == 0)
                    p.second_left = p.first_left + p.first_width + coord_t'($urandom_range(0, 3));
                else
                    p.second_top = p.first_top + p.first_height + coord_t'($urandom_range(0, 3));
            end
            default:
            begin
            end
        endcase
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            offered   <= '0;
            idle_left <= 0;
        end
        else
        begin
            box_pair_t next_pair;
            if (in_valid && in_ready)
            begin
                expected_scores.push_back(predict_score(offered));
            end
            if (in_valid && !in_ready)
            begin
                // The beat is held until it is taken.
            end
            else if (idle_left > 0)
            begin
                idle_left <= idle_left - 1;
                in_valid  <= 1'b0;
            end
            else if (pending_pairs.size() == 0
                     || (pending_pairs[0].drain && expected_scores.size() != 0))
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                next_pair = pending_pairs.pop_front();
                offered  <= next_pair;
                in_valid <= 1'b1;
                if (pending_pairs.size() >= TAIL_PAIRS && $urandom_range(0, 7) == 0)
                begin
                    idle_left <= $urandom_range(1, 4);
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            score_t want;
            if (out_valid && out_ready)
            begin
                if (expected_scores.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat, ratio %0d empty %0b",
                                              overlap_ratio, union_empty));
                end
                else
                begin
                    want = expected_scores.pop_front();
                    if (overlap_ratio !== want.ratio)
                    begin
                        report_mismatch($sformatf("overlap_ratio %0d, expected %0d",
                                                  overlap_ratio, want.ratio));
                    end
                    if (union_empty !== want.empty)
                    begin
                        report_mismatch($sformatf("union_empty %0b, expected %0b",
                                                  union_empty, want.empty));
                    end
                end
                results_seen++;
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (!long_hold_done && results_seen >= 500)
            begin
                long_hold_done = 1'b1;
                hold_left <= LONG_HOLD - 1;
                out_ready <= 1'b0;
            end
            else if (pending_pairs.size() >= TAIL_PAIRS && $urandom_range(0, 7) == 0)
            begin
                hold_left <= $urandom_range(0, 3);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        box_pair_t p;
        // Both boxes empty, then empty boxes at different places.
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(4095, 4095, 0, 0, 17, 300, 0, 0));
        pending_pairs.push_back(make_pair(10, 10, 4095, 0, 20, 20, 0, 4095));
        // Identical boxes give exactly one.
        pending_pairs.push_back(make_pair(0, 0, 4095, 4095, 0, 0, 4095, 4095));
        pending_pairs.push_back(make_pair(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
        pending_pairs.push_back(make_pair(5, 7, 1, 1, 5, 7, 1, 1));
        // Disjoint along x, along y, and touching edges.
        pending_pairs.push_back(make_pair(0, 0, 100, 100, 200, 0, 100, 100));
        pending_pairs.push_back(make_pair(0, 0, 100, 100, 0, 200, 100, 100));
        pending_pairs.push_back(make_pair(0, 0, 100, 100, 100, 0, 100, 100));
        pending_pairs.push_back(make_pair(50, 0, 100, 100, 0, 100, 100, 100));
        pending_pairs.push_back(make_pair(4095, 4095, 4095, 4095, 0, 0, 4095, 4095));
        // One box has no area, the other has some.
        pending_pairs.push_back(make_pair(10, 10, 0, 50, 0, 0, 100, 100));
        pending_pairs.push_back(make_pair(0, 0, 4095, 4095, 0, 0, 4095, 0));
        // Containment and partial overlap.
        pending_pairs.push_back(make_pair(0, 0, 4095, 4095, 2000, 2000, 1, 1));
        pending_pairs.push_back(make_pair(0, 0, 100, 100, 25, 25, 50, 50));
        pending_pairs.push_back(make_pair(0, 0, 100, 100, 50, 0, 100, 100));
        pending_pairs.push_back(make_pair(0, 0, 3, 3, 1, 1, 3, 3));
        pending_pairs.push_back(make_pair(2048, 1024, 4095, 4095, 3000, 3000, 4095, 4095));
        pending_pairs.push_back(make_pair(1365, 2730, 2730, 1365, 2730, 1365, 1365, 2730));
        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            p = random_pair();
            p.drain = (i == 400 || i == 1100);
            pending_pairs.push_back(p);
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_pairs.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_scores.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
